// File: sv/assert_macros.svh
// assertion macros used by the stt_ctrl module of the step_and_turn_angle rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/stt_pkg.sv
// constants, types and the arctangent table of the step and turn angle block
// no dependencies
`default_nettype none

package stt_pkg;

  localparam int COORD_WIDTH       = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_WIDTH       = 16;
  localparam int ZW                = 32;
  localparam int GUARD_SHIFT       = 24;
  localparam int ATAN_ENTRIES      = 24;
  localparam int ATAN_IDX_W        = $clog2(ATAN_ENTRIES);

  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                CORDIC_ITERATIONS : ATAN_ENTRIES;
  localparam int SQRT_STEPS   = COORD_WIDTH;
  localparam int RUN_STEPS    = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int STEP_W       = $clog2(RUN_STEPS);

  // scaled vector plus room for the cordic gain and the diagonal
  localparam int XY_W  = COORD_WIDTH + GUARD_SHIFT + 3;
  localparam int SUM_W = 2 * COORD_WIDTH;
  localparam int REM_W = COORD_WIDTH + 3;

  localparam logic [ZW-1:0] Z_QUARTER     = 32'h4000_0000;
  localparam logic [ZW-1:0] Z_NEG_QUARTER = 32'hC000_0000;
  localparam logic [ZW-1:0] HEAD_ROUND    = 32'h0000_8000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] length_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic        [STEP_W-1:0]      step_t;

  typedef struct packed {
    logic  load;
    logic  prep;
    logic  step;
    logic  finish;
    step_t idx;
  } stt_cmd_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [ZW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/stt_in_if.sv
// input channel: one displacement and the track start flag per transfer
// depends on stt_pkg
`default_nettype none

interface stt_in_if;
  import stt_pkg::*;

  logic   valid;
  logic   ready;
  coord_t dx;
  coord_t dy;
  logic   track_start;

  modport source (output valid, output dx, output dy, output track_start, input ready);
  modport sink   (input valid, input dx, input dy, input track_start, output ready);
endinterface

`default_nettype wire

// File: sv/stt_out_if.sv
// result channel: step length, heading and turn angle per transfer
// depends on stt_pkg
`default_nettype none

interface stt_out_if;
  import stt_pkg::*;

  logic    valid;
  logic    ready;
  length_t stride_len;
  angle_t  heading;
  angle_t  turn_delta;
  logic    turn_valid;

  modport source (output valid, output stride_len, output heading, output turn_delta,
                  output turn_valid, input ready);
  modport sink   (input valid, input stride_len, input heading, input turn_delta,
                  input turn_valid, output ready);
endinterface

`default_nettype wire

// File: sv/stt_ctrl.sv
// controller: sequences load, setup, iteration steps and result write
// depends on stt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      stt_pkg::stt_cmd_t cmd
);
  import stt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_RUN, ST_FIN} state_t;

  state_t state_r, state_nxt;
  step_t  cnt_r, cnt_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.prep   = (state_r == ST_PREP);
    cmd.step   = (state_r == ST_RUN);
    cmd.finish = (state_r == ST_FIN) && (!out_valid_r || out_ready);
    cmd.idx    = cnt_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_RUN;
        cnt_nxt   = '0;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if ({1'b0, cnt_r} == (STEP_W+1)'(RUN_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // result register frees up or is taken this cycle
        if (!out_valid_r || out_ready) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_load_then_prep, clk, rst_n, cmd.load, state_r == ST_PREP)
  `ASSERT_NEXT(a_prep_then_run, clk, rst_n, state_r == ST_PREP, state_r == ST_RUN && cnt_r == '0)
  `ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid_r && state_r == ST_IDLE)

endmodule

`default_nettype wire

// File: sv/stt_datapath.sv
// datapath: squares, bit-serial square root, cordic vectoring, turn angle
// depends on stt_pkg
`default_nettype none

module stt_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stt_pkg::stt_cmd_t cmd,
  input  wire stt_pkg::coord_t   in_dx,
  input  wire stt_pkg::coord_t   in_dy,
  input  wire logic              in_track_start,
  output      stt_pkg::length_t  out_stride_len,
  output      stt_pkg::angle_t   out_heading,
  output      stt_pkg::angle_t   out_turn_delta,
  output      logic              out_turn_valid
);
  import stt_pkg::*;

  localparam int XPAD = XY_W - COORD_WIDTH - GUARD_SHIFT;

  coord_t                  dx_r, dy_r;
  logic                    start_r, zero_r;
  logic [SUM_W-1:0]        sqx_r, sqy_r, s_r;
  logic signed [SUM_W-1:0] prod_x, prod_y;

  logic signed [XY_W-1:0]  x_r, y_r, x_init, y_init, xs, ys;
  logic [ZW-1:0]           z_r, atan_val, z_round;

  length_t                 root_r, length;
  logic [REM_W-1:0]        rem_r, rem_sh, trial;
  logic                    take;

  angle_t                  prev_r, head;
  logic                    have_prev_r, turn_ok;

  length_t                 len_out_r;
  angle_t                  head_out_r, turn_out_r;
  logic                    turn_valid_out_r;

  logic                    do_cordic, do_sqrt;

  assign prod_x = in_dx * in_dx;
  assign prod_y = in_dy * in_dy;

  assign x_init = {{XPAD{dy_r[COORD_WIDTH-1]}}, dy_r, {GUARD_SHIFT{1'b0}}};
  assign y_init = {{XPAD{dx_r[COORD_WIDTH-1]}}, dx_r, {GUARD_SHIFT{1'b0}}};

  assign do_cordic = cmd.step && ({1'b0, cmd.idx} < (STEP_W+1)'(CORDIC_STEPS));
  assign do_sqrt   = cmd.step && ({1'b0, cmd.idx} < (STEP_W+1)'(SQRT_STEPS));

  // arithmetic shift is the floor shift
  assign xs       = x_r >>> cmd.idx;
  assign ys       = y_r >>> cmd.idx;
  assign atan_val = atan_lut(ATAN_IDX_W'(cmd.idx));

  // one result bit per step, two radicand bits in
  assign rem_sh = {rem_r[REM_W-3:0], s_r[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  // round half up: remainder above the root means closer to root + 1
  assign length  = (rem_r > REM_W'(root_r)) ? root_r + 1'b1 : root_r;
  assign z_round = z_r + HEAD_ROUND;
  assign head    = zero_r ? '0 : angle_t'(z_round[ZW-1 -: ANGLE_WIDTH]);
  assign turn_ok = have_prev_r && !start_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r    <= in_dx;
      dy_r    <= in_dy;
      start_r <= in_track_start;
      zero_r  <= (in_dx == '0) && (in_dy == '0);
      sqx_r   <= prod_x;
      sqy_r   <= prod_y;
    end

    if (cmd.prep) begin
      s_r    <= sqx_r + sqy_r;
      root_r <= '0;
      rem_r  <= '0;
      if (dy_r[COORD_WIDTH-1]) begin
        // pre-rotate into the right half plane
        if (!dx_r[COORD_WIDTH-1]) begin
          x_r <= y_init;
          y_r <= -x_init;
          z_r <= Z_QUARTER;
        end else begin
          x_r <= -y_init;
          y_r <= x_init;
          z_r <= Z_NEG_QUARTER;
        end
      end else begin
        x_r <= x_init;
        y_r <= y_init;
        z_r <= '0;
      end
    end

    if (do_cordic) begin
      if (!y_r[XY_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_val;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_val;
      end
    end

    if (do_sqrt) begin
      s_r <= s_r << 2;
      if (take) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[COORD_WIDTH-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[COORD_WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.finish) begin
      len_out_r        <= length;
      head_out_r       <= head;
      turn_out_r       <= turn_ok ? head - prev_r : '0;
      turn_valid_out_r <= turn_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.finish) begin
      prev_r      <= head;
      have_prev_r <= 1'b1;
    end
  end

  assign out_stride_len = len_out_r;
  assign out_heading    = head_out_r;
  assign out_turn_delta = turn_out_r;
  assign out_turn_valid = turn_valid_out_r;

endmodule

`default_nettype wire

// File: sv/step_and_turn_angle.sv
// step length, heading and turn angle of a movement track.
// sequence from input transfer to result valid: a setup state, 16 shared
// steps (cordic rotation and square root bit in parallel), one result write.
// items are taken one at a time; the next item is taken while a finished result waits
// in the output register, and the result write stalls until that register is free.
// synchronous active-low reset clears the controller and the previous heading.
`default_nettype none

module step_and_turn_angle (
  input wire logic clk,
  input wire logic rst_n,
  stt_in_if.sink   in_ch,
  stt_out_if.source out_ch
);
  import stt_pkg::*;

  stt_cmd_t cmd;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  stt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_dx           (in_ch.dx),
    .in_dy           (in_ch.dy),
    .in_track_start  (in_ch.track_start),
    .out_stride_len  (out_ch.stride_len),
    .out_heading     (out_ch.heading),
    .out_turn_delta  (out_ch.turn_delta),
    .out_turn_valid  (out_ch.turn_valid)
  );

endmodule

`default_nettype wire

// File: sim/step_and_turn_angle_tb.sv
// testbench of step_and_turn_angle: directed and random displacements with random
// idling on both channels, results checked against a predictor of length, heading and turn
// depends on stt_pkg, stt_in_if, stt_out_if and step_and_turn_angle
`default_nettype none

module step_and_turn_angle_tb;
  import stt_pkg::*;

  typedef struct {
    length_t stride_len;
    angle_t  heading;
    angle_t  turn_delta;
    logic    turn_valid;
  } step_result_t;

  class turn_scoreboard;
    angle_t       last_heading;
    bit           have_last;
    step_result_t pending_q[$];
    int           mismatches;

    function new();
      last_heading = '0;
      have_last    = 1'b0;
      mismatches   = 0;
    endfunction

    // atan(2^-i) in 2^32 units per turn
    function bit [31:0] atan_step(int i);
      case (i)
        0:  return 32'd536870912;
        1:  return 32'd316933406;
        2:  return 32'd167458907;
        3:  return 32'd85004756;
        4:  return 32'd42667331;
        5:  return 32'd21354465;
        6:  return 32'd10679838;
        7:  return 32'd5340245;
        8:  return 32'd2670163;
        9:  return 32'd1335087;
        10: return 32'd667544;
        11: return 32'd333772;
        12: return 32'd166886;
        13: return 32'd83443;
        14: return 32'd41722;
        15: return 32'd20861;
        16: return 32'd10430;
        17: return 32'd5215;
        18: return 32'd2608;
        19: return 32'd1304;
        20: return 32'd652;
        21: return 32'd326;
        22: return 32'd163;
        23: return 32'd81;
        default: return 32'd0;
      endcase
    endfunction

    function length_t rounded_length(coord_t dx, coord_t dy);
      longint unsigned sq, root, rem, b;
      sq   = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
      root = 0;
      rem  = sq;
      b    = 64'h4000_0000_0000_0000;
      while (b > sq) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem  = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      // round half up
      if (sq - root * root > root) root++;
      return root[COORD_WIDTH-1:0];
    endfunction

    // vectoring cordic on (dy, dx), angle measured from +y toward +x
    function angle_t bearing_of(coord_t dx, coord_t dy);
      longint    xa, ya, t, xs, ys;
      bit [31:0] z, rounded;
      if (dx == 0 && dy == 0) return '0;
      xa = longint'(dy) <<< GUARD_SHIFT;
      ya = longint'(dx) <<< GUARD_SHIFT;
      z  = '0;
      if (xa < 0) begin
        t = xa;
        if (ya >= 0) begin
          xa = ya;
          ya = -t;
          z  = Z_QUARTER;
        end else begin
          xa = -ya;
          ya = t;
          z  = Z_NEG_QUARTER;
        end
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
        xs = xa >>> i;
        ys = ya >>> i;
        if (ya >= 0) begin
          xa = xa + ys;
          ya = ya - xs;
          z  = z + atan_step(i);
        end else begin
          xa = xa - ys;
          ya = ya + xs;
          z  = z - atan_step(i);
        end
      end
      rounded = z + HEAD_ROUND;
      return angle_t'(rounded[31:16]);
    endfunction

    function void note_step(coord_t dx, coord_t dy, logic start);
      step_result_t r;
      r.stride_len = rounded_length(dx, dy);
      r.heading    = bearing_of(dx, dy);
      r.turn_valid = have_last && !start;
      r.turn_delta = r.turn_valid ? angle_t'(r.heading - last_heading) : angle_t'(0);
      last_heading = r.heading;
      have_last    = 1'b1;
      pending_q.push_back(r);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(step_result_t got);
      step_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with no item outstanding: len %0d head %0d",
                         got.stride_len, got.heading));
      end else begin
        want = pending_q.pop_front();
        if (got.stride_len !== want.stride_len || got.heading !== want.heading ||
            got.turn_delta !== want.turn_delta || got.turn_valid !== want.turn_valid)
          report($sformatf("got len %0d head %0d turn %0d tv %0b, want %0d %0d %0d %0b",
                           got.stride_len, got.heading, got.turn_delta, got.turn_valid,
                           want.stride_len, want.heading, want.turn_delta,
                           want.turn_valid));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct;
  turn_scoreboard track_sb = new();

  always #10 clk = ~clk;

  stt_in_if  in_if();
  stt_out_if out_if();

  step_and_turn_angle uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  task automatic send_step(input coord_t dx, input coord_t dy, input logic start);
    in_if.valid       <= 1'b1;
    in_if.dx          <= dx;
    in_if.dy          <= dy;
    in_if.track_start <= start;
    do @(posedge clk); while (!in_if.ready);
    track_sb.note_step(dx, dy, start);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 32) - 16);
      1: begin
        case ($urandom_range(0, 4))
          0: return coord_t'(-32768);
          1: return coord_t'(32767);
          2: return coord_t'(-1);
          3: return coord_t'(1);
          default: return coord_t'(0);
        endcase
      end
      2: return coord_t'($urandom_range(0, 4096) - 2048);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // result side: random stalls plus one long hold-off to back the block up
  initial begin : result_sink
    int           stall_left;
    int           results_seen;
    bit           hold_done;
    step_result_t got;
    stall_left   = 0;
    results_seen = 0;
    hold_done    = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.stride_len = out_if.stride_len;
        got.heading    = out_if.heading;
        got.turn_delta = out_if.turn_delta;
        got.turn_valid = out_if.turn_valid;
        track_sb.check_result(got);
        results_seen++;
      end
      if (!hold_done && results_seen == 60) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int     sent, track_len, mode, wait_cycles;
    coord_t dx, dy;
    logic   start;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.dx          <= '0;
    in_if.dy          <= '0;
    in_if.track_start <= 1'b0;
    idle_pct = 30;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first item after reset has no previous heading, then a half turn
    send_step(16'sd0, 16'sd100, 1'b0);
    send_step(16'sd0, -16'sd100, 1'b0);
    send_step(16'sd0, 16'sd0, 1'b0);
    send_step(16'sd5, 16'sd5, 1'b0);
    send_step(16'sd32767, 16'sd32767, 1'b0);
    send_step(-16'sd32768, -16'sd32768, 1'b0);
    send_step(-16'sd32768, 16'sd32767, 1'b0);
    send_step(16'sd32767, -16'sd32768, 1'b0);
    send_step(-16'sd32768, 16'sd0, 1'b1);
    send_step(16'sd0, -16'sd32768, 1'b0);
    send_step(16'sd32767, 16'sd0, 1'b0);
    send_step(-16'sd1, -16'sd1, 1'b0);
    send_step(16'sd1, 16'sd0, 1'b1);
    send_step(-16'sd1, 16'sd0, 1'b1);
    send_step(16'sd0, 16'sd1, 1'b0);
    send_step(16'sd0, -16'sd1, 1'b0);
    send_step(-16'sd1, 16'sd0, 1'b0);
    send_step(16'sd0, 16'sd0, 1'b1);
    send_step(16'sd0, 16'sd0, 1'b0);
    send_step(16'sd3, -16'sd4, 1'b0);
    send_step(-16'sd300, 16'sd400, 1'b0);
    send_step(16'sd1, -16'sd32768, 1'b0);

    sent = 0;
    dx   = '0;
    dy   = '0;
    while (sent < 480) begin
      track_len = $urandom_range(1, 30);
      mode      = $urandom_range(0, 3);
      for (int j = 0; j < track_len && sent < 480; j++) begin
        if (sent % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 10;
            2: idle_pct = 30;
            default: idle_pct = 50;
          endcase
        end
        // calm tail with no idling on either side
        if (sent >= 420) idle_pct = 0;
        if (mode == 0 && j > 0) begin
          // smooth walk: small change of direction per step
          dx = dx + coord_t'($urandom_range(0, 64) - 32);
          dy = dy + coord_t'($urandom_range(0, 64) - 32);
        end else begin
          dx = pick_coord();
          dy = pick_coord();
          case ($urandom_range(0, 9))
            0: dx = '0;
            1: dy = '0;
            2: dy = dx;
            3: dy = -dx;
            default: ;
          endcase
        end
        if (j == 0) start = ($urandom_range(0, 9) != 0);
        else start = ($urandom_range(0, 39) == 0);
        send_step(dx, dy, start);
        sent++;
      end
    end
    in_if.valid <= 1'b0;

    wait_cycles = 0;
    while (track_sb.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (track_sb.pending() != 0)
      track_sb.report($sformatf("%0d results never arrived", track_sb.pending()));
    if (track_sb.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
